/* design/tmma_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmma_pkg: shared types, constants and arithmetic helpers
// Sizes, command and register codes, and Q-format rounding and saturation
// used by the triangular matrix multiply-add core.
// ----------------------------------------------------------------------------
package tmma_pkg;

  localparam int MAX_DIM   = 16;
  localparam int FRAC_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RND_W  = 64 - FRAC_BITS;
  localparam int ACC_W  = RND_W + $clog2(MAX_DIM);

  localparam int CFG_IDX_W = 3;
  localparam int DIM_REG_W = 5;

  typedef logic signed [31:0] word_t;

  // s_tdata layout, lowest bits last
  typedef struct packed {
    word_t      value;
    logic [3:0] col_index;
    logic [3:0] row_index;
  } in_beat_t;

  typedef struct packed {
    logic start;
    logic skip;
    logic term_valid;
    logic term_last;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

  localparam logic [1:0] CMD_WRITE_T = 2'd0;
  localparam logic [1:0] CMD_WRITE_B = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic MODE_UPPER = 1'b0;
  localparam logic MODE_LOWER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BCOLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd5;

  localparam logic [DIM_REG_W-1:0] DIM_RESET   = 5'd16;
  localparam word_t                ALPHA_RESET = 32'sd65536;
  localparam word_t                BETA_RESET  = 32'sd0;

  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] SAT_HI     = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO     = -64'sd2147483648;

  // round half up, drop FRAC_BITS fraction bits
  function automatic logic signed [RND_W-1:0] rnd_q(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + ROUND_HALF;
    return s[63:FRAC_BITS];
  endfunction

  function automatic word_t sat32(input logic signed [63:0] x);
    word_t r;
    if (x > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (x < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] dim_clamp(input logic [DIM_REG_W-1:0] r);
    logic [CNT_W-1:0] d;
    if (int'(r) > MAX_DIM) begin
      d = CNT_W'(MAX_DIM);
    end else begin
      d = CNT_W'(r);
    end
    return d;
  endfunction

endpackage
`default_nettype wire

/* design/tmma_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmma_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tmma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/tmma_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmma_mac: shared multiplier and accumulator
// Accumulates rounded T*B terms, then reuses the multiplier for the alpha
// and beta scaling and forms the saturated C element.
// ----------------------------------------------------------------------------
module tmma_mac (
  input  logic                clk,
  input  logic                rst,
  input  tmma_pkg::mac_ctl_t  ctl,
  input  tmma_pkg::word_t     c_in,
  input  tmma_pkg::word_t     alpha,
  input  tmma_pkg::word_t     beta,
  input  tmma_pkg::word_t     t_in,
  input  tmma_pkg::word_t     b_in,
  output tmma_pkg::mac_stat_t stat,
  output tmma_pkg::word_t     result
);
  import tmma_pkg::*;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_TERMS = 3'd1;
  localparam logic [2:0] M_ALPHA = 3'd2;
  localparam logic [2:0] M_BETA  = 3'd3;
  localparam logic [2:0] M_SUM   = 3'd4;

  logic [2:0]               st;
  logic                     prod_v;
  logic                     prod_last;
  logic                     done;
  logic signed [63:0]       prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RND_W-1:0]  alpha_term;
  word_t                    c_q;
  word_t                    mul_a;
  word_t                    mul_b;

  always_comb begin
    unique case (st)
      M_ALPHA: begin
        mul_a = alpha;
        mul_b = sat32(64'(acc));
      end
      M_BETA: begin
        mul_a = beta;
        mul_b = c_q;
      end
      default: begin
        mul_a = t_in;
        mul_b = b_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    prod_last <= ctl.term_last;
    if (ctl.start) begin
      acc <= '0;
      c_q <= c_in;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(rnd_q(prod));
    end
    if (st == M_BETA) begin
      alpha_term <= rnd_q(prod);
    end
    if (st == M_SUM) begin
      result <= sat32(64'(alpha_term) + 64'(rnd_q(prod)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= M_IDLE;
      prod_v <= 1'b0;
      done   <= 1'b0;
    end else begin
      prod_v <= ctl.term_valid;
      done   <= 1'b0;
      unique case (st)
        M_IDLE: begin
          if (ctl.start) begin
            st <= ctl.skip ? M_ALPHA : M_TERMS;
          end
        end
        M_TERMS: begin
          if (prod_v && prod_last) begin
            st <= M_ALPHA;
          end
        end
        M_ALPHA: st <= M_BETA;
        M_BETA:  st <= M_SUM;
        M_SUM: begin
          st   <= M_IDLE;
          done <= 1'b1;
        end
        default: st <= M_IDLE;
      endcase
    end
  end

  assign stat.busy = (st != M_IDLE);
  assign stat.done = done;

endmodule
`default_nettype wire

/* design/triangular_matrix_mul_add_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// triangular_matrix_mul_add_core: one element of C = beta*C + alpha*T*B
// Q16.16 fixed point, T upper or lower triangular, result saturated.
//
// Input beats: s_tuser = command, s_tdata = row, col, value. Command 0 and 1
// write a T or B entry; command 2 brings the old C(row,col) and returns the
// new one. One output beat per input beat: m_tdata = value, m_tuser = status
// (1 for an index outside the configured sizes or an unknown command).
// Writes, errors and pass-through rows go from the pending result into the
// output register, and the next beat is accepted once it has moved there.
// Compute with L product terms (1 <= L <= 16): the read ports of the T and
// B memories feed one pair a cycle into the single multiplier, then a tail
// of three steps (alpha scaling, beta scaling, saturated sum) follows. A
// lower-mode compute with zero columns has no terms and goes straight to
// the tail.
// An output beat waits in its register while m_tready is low; the next input
// beat is already taken and worked on, and its result waits behind it.
// Reset (rst, synchronous) restores register defaults and drops pending
// beats; T and B contents are undefined until written. Config writes
// (cfg_wen) must be made only while no beat is in flight; not enforced here.
// ----------------------------------------------------------------------------
module triangular_matrix_mul_add_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [tmma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [39:0]                    s_tdata,   // row_index, col_index, value
  input  logic [1:0]                     s_tuser,   // command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // result_value
  output logic                           m_tuser    // status
);
  import tmma_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

  logic [1:0]           state;
  logic                 mode;
  logic [DIM_REG_W-1:0] tri_rows;
  logic [DIM_REG_W-1:0] tri_cols;
  logic [DIM_REG_W-1:0] b_cols;
  word_t                alpha_gain;
  word_t                beta_gain;

  logic [IDX_W-1:0]     k;
  logic [IDX_W-1:0]     k_hi;
  logic [ADDR_W-1:0]    t_raddr;
  logic [ADDR_W-1:0]    b_raddr;
  logic                 rd_v;
  logic                 rd_last;
  word_t                pend_val;
  logic                 pend_st;

  in_beat_t             ib;
  logic                 accept;
  logic [CNT_W-1:0]     m;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     p;
  logic [CNT_W-1:0]     mm;
  logic [CNT_W-1:0]     n_last;
  logic                 t_ok;
  logic                 b_ok;
  logic                 c_ok;
  logic                 pass;
  logic                 no_terms;
  logic [IDX_W-1:0]     row;
  logic [IDX_W-1:0]     col;
  logic [IDX_W-1:0]     lo;
  logic [IDX_W-1:0]     hi;
  logic                 t_we;
  logic                 b_we;
  logic [ADDR_W-1:0]    waddr;
  word_t                t_rdata;
  word_t                b_rdata;
  mac_ctl_t             mac_ctl;
  mac_stat_t            mac_stat;
  word_t                mac_result;

  assign ib       = in_beat_t'(s_tdata);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    m        = dim_clamp(tri_rows);
    n        = dim_clamp(tri_cols);
    p        = dim_clamp(b_cols);
    mm       = (m < n) ? m : n;
    n_last   = n - CNT_W'(1);
    t_ok     = (ib.row_index < m) && (ib.col_index < n);
    b_ok     = (ib.row_index < n) && (ib.col_index < p);
    c_ok     = (ib.row_index < m) && (ib.col_index < p);
    pass     = (mode == MODE_UPPER) && (ib.row_index >= mm);
    no_terms = (mode == MODE_LOWER) && (n == '0);
    row      = IDX_W'(ib.row_index);
    col      = IDX_W'(ib.col_index);
    if (mode == MODE_UPPER) begin
      lo = row;
      hi = IDX_W'(n_last);
    end else begin
      lo = '0;
      hi = (ib.row_index < n) ? row : IDX_W'(n_last);
    end
  end

  assign waddr = addr_of(row, col);
  assign t_we  = accept && (s_tuser == CMD_WRITE_T) && t_ok;
  assign b_we  = accept && (s_tuser == CMD_WRITE_B) && b_ok;

  assign mac_ctl.start      = accept && (s_tuser == CMD_COMPUTE) && c_ok && !pass;
  assign mac_ctl.skip       = no_terms;
  assign mac_ctl.term_valid = rd_v;
  assign mac_ctl.term_last  = rd_last;

  tmma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_t_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (waddr),
    .wdata (ib.value),
    .re    (state == ST_RUN),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  tmma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (ib.value),
    .re    (state == ST_RUN),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  tmma_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .c_in   (ib.value),
    .alpha  (alpha_gain),
    .beta   (beta_gain),
    .t_in   (t_rdata),
    .b_in   (b_rdata),
    .stat   (mac_stat),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      rd_v       <= 1'b0;
      rd_last    <= 1'b0;
      mode       <= MODE_UPPER;
      tri_rows   <= DIM_RESET;
      tri_cols   <= DIM_RESET;
      b_cols     <= DIM_RESET;
      alpha_gain <= ALPHA_RESET;
      beta_gain  <= BETA_RESET;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_MODE:  mode       <= cfg_wdata[0];
          REG_ROWS:  tri_rows   <= cfg_wdata[DIM_REG_W-1:0];
          REG_COLS:  tri_cols   <= cfg_wdata[DIM_REG_W-1:0];
          REG_BCOLS: b_cols     <= cfg_wdata[DIM_REG_W-1:0];
          REG_ALPHA: alpha_gain <= cfg_wdata;
          REG_BETA:  beta_gain  <= cfg_wdata;
          default: ;
        endcase
      end

      rd_v    <= (state == ST_RUN);
      rd_last <= (state == ST_RUN) && (k == k_hi);

      // a pending result reloads the output register itself
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (s_tuser)
              CMD_WRITE_T: begin
                pend_val <= '0;
                pend_st  <= !t_ok;
                state    <= ST_DONE;
              end
              CMD_WRITE_B: begin
                pend_val <= '0;
                pend_st  <= !b_ok;
                state    <= ST_DONE;
              end
              CMD_COMPUTE: begin
                if (!c_ok) begin
                  pend_val <= '0;
                  pend_st  <= 1'b1;
                  state    <= ST_DONE;
                end else if (pass) begin
                  pend_val <= ib.value;
                  pend_st  <= 1'b0;
                  state    <= ST_DONE;
                end else if (no_terms) begin
                  state <= ST_WAIT;
                end else begin
                  k       <= lo;
                  k_hi    <= hi;
                  t_raddr <= addr_of(row, lo);
                  b_raddr <= addr_of(lo, col);
                  state   <= ST_RUN;
                end
              end
              default: begin
                pend_val <= '0;
                pend_st  <= 1'b1;
                state    <= ST_DONE;
              end
            endcase
          end
        end
        ST_RUN: begin
          k       <= k + IDX_W'(1);
          t_raddr <= t_raddr + ADDR_W'(1);
          b_raddr <= b_raddr + ADDR_W'(MAX_DIM);
          if (k == k_hi) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (mac_stat.done) begin
            pend_val <= mac_result;
            pend_st  <= 1'b0;
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= pend_val;
            m_tuser  <= pend_st;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_start_mac_idle: assert property (@(posedge clk) disable iff (rst)
    mac_ctl.start |-> !mac_stat.busy)
    else $error("mac started while busy");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !(t_we || b_we))
    else $error("store written during a compute");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_stat.done |-> (state == ST_WAIT))
    else $error("mac result with no compute waiting");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && (!m_tvalid || m_tready)) |=> m_tvalid)
    else $error("pending result not moved to output");

endmodule
`default_nettype wire
